[hdl/hilbert_fir_envelope_detector_unit_assert.svh]
// Assertion macros used by the envelope detector back end.
// Depends on nothing; files take it in by `include.
`ifndef HILBERT_FIR_ENVELOPE_DETECTOR_UNIT_ASSERT_SVH
`define HILBERT_FIR_ENVELOPE_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define HFED_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define HFED_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hdl/hfed_pkg.sv]
// Shared types, constants and the square-root step for the envelope detector.
// Depends on nothing.
package hfed_pkg;

    localparam int TAPS_DEF    = 31;
    localparam int QUEUE_DEPTH = 2;
    localparam int SQRT_CYCLES = 9;   // two root bits per cycle, 18 bits
    localparam int ROOT_W      = 18;
    localparam int REM_W       = 22;

    localparam logic [12:0] SEEN_CAP = 13'd8191;

    localparam logic MODE_COEF   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [4:0]         tap_index;
        logic signed [15:0] coef_value;
        logic signed [15:0] sample_value;
        logic               last_sample;
    } in_item_t;

    typedef struct packed {
        logic [15:0] envelope;
        logic        last_out;
    } out_item_t;

    // Classified request handed from front to back.
    typedef struct packed {
        logic               is_sample;
        logic               wr_ok;
        logic [4:0]         tap_idx;
        logic signed [15:0] coef;
        logic signed [15:0] sample;
        logic               last;
    } cmd_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    // One restoring digit step of the integer square root.
    function automatic sqrt_t sqrt_step(logic [REM_W-1:0] rem, logic [ROOT_W-1:0] root,
                                        logic [1:0] pair);
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        sqrt_t            res;
        rem_sh = {rem[REM_W-3:0], pair};
        trial  = REM_W'({root, 2'b01});
        if (rem_sh >= trial) begin
            res.rem  = rem_sh - trial;
            res.root = {root[ROOT_W-2:0], 1'b1};
        end else begin
            res.rem  = rem_sh;
            res.root = {root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

[hdl/hfed_front.sv]
// Front end: accepts input items, classifies them and registers the request.
// Depends on hfed_pkg.
module hfed_front #(
    parameter int TAPS = hfed_pkg::TAPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hfed_pkg::in_item_t s_data,
    output logic               req_valid,
    input  logic               req_ready,
    output hfed_pkg::cmd_t     req_data
);

    logic           vld_reg;
    hfed_pkg::cmd_t cmd_reg;
    hfed_pkg::cmd_t cmd_next;

    assign s_ready   = !vld_reg || req_ready;
    assign req_valid = vld_reg;
    assign req_data  = cmd_reg;

    always_comb begin
        cmd_next.is_sample = (s_data.mode == hfed_pkg::MODE_SAMPLE);
        // out-of-range coefficient writes are flagged here and dropped in the back end
        cmd_next.wr_ok     = (s_data.mode == hfed_pkg::MODE_COEF) &&
                             (7'(s_data.tap_index) < 7'(TAPS));
        cmd_next.tap_idx   = s_data.tap_index;
        cmd_next.coef      = s_data.coef_value;
        cmd_next.sample    = s_data.sample_value;
        cmd_next.last      = s_data.last_sample;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_ready) begin
            vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

[hdl/hfed_queue.sv]
// Short request queue between front and back ends.
// Depends on hfed_pkg.
module hfed_queue #(
    parameter int DEPTH = hfed_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  hfed_pkg::cmd_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output hfed_pkg::cmd_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hfed_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/hfed_back.sv]
// Back end: delay line, tap store, shared MAC, iterative square root, output register.
// Depends on hfed_pkg and the assertion macro header.
`include "hilbert_fir_envelope_detector_unit_assert.svh"
module hfed_back #(
    parameter int TAPS = hfed_pkg::TAPS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  hfed_pkg::cmd_t      q_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hfed_pkg::out_item_t m_data
);

    localparam int HALF   = TAPS / 2;
    localparam int IDX_W  = $clog2(TAPS);
    localparam int STEP_W = $clog2(HALF + 1);
    localparam int ACC_W  = 33 + $clog2(TAPS);
    localparam int CNT_W  = $clog2(hfed_pkg::SQRT_CYCLES);
    localparam int RT_W   = hfed_pkg::ROOT_W;
    localparam int RM_W   = hfed_pkg::REM_W;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MAC  = 7'b0000010,
        ST_MAG  = 7'b0000100,
        ST_SUM  = 7'b0001000,
        ST_SQRT = 7'b0010000,
        ST_RES  = 7'b0100000,
        ST_ADV  = 7'b1000000
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic signed [15:0]        dl_reg  [TAPS];   // dl_reg[0] is the newest sample
    logic signed [15:0]        tap_reg [TAPS];
    logic [12:0]               seen_reg;
    logic                      flush_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [IDX_W-1:0]          k_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      sat_reg;
    logic [61:0]               magsq_reg;
    logic [35:0]               rad_reg;
    logic [RM_W-1:0]           rem_reg;
    logic [RT_W-1:0]           root_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      m_valid_reg;
    hfed_pkg::out_item_t       m_data_reg;

    logic [12:0]               seen_inc;
    logic                      emit_first;
    logic [STEP_W-1:0]         step_inc;
    logic                      emit_adv;
    logic signed [31:0]        prod;
    logic [ACC_W-1:0]          acc_abs;
    logic                      mag_big;
    logic [30:0]               mag_lo;
    logic signed [31:0]        ssq;
    hfed_pkg::sqrt_t           st1;
    hfed_pkg::sqrt_t           st2;
    logic                      out_free;
    logic [15:0]               env;

    assign q_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;
    assign out_free   = !m_valid_reg || m_ready;

    assign seen_inc   = (seen_reg == hfed_pkg::SEEN_CAP) ? seen_reg : seen_reg + 1'b1;
    assign emit_first = seen_inc > 13'(HALF);
    assign step_inc   = step_reg + 1'b1;
    assign emit_adv   = (14'(seen_reg) + 14'(step_inc)) >= 14'(HALF + 1);

    assign prod       = tap_reg[k_reg] * dl_reg[IDX_W'(TAPS - 1) - k_reg];
    assign acc_abs    = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign mag_big    = |acc_abs[ACC_W-1:31];
    assign mag_lo     = acc_abs[30:0];
    assign ssq        = dl_reg[HALF] * dl_reg[HALF];

    assign st1        = hfed_pkg::sqrt_step(rem_reg, root_reg, rad_reg[35:34]);
    assign st2        = hfed_pkg::sqrt_step(st1.rem, st1.root, rad_reg[33:32]);
    assign env        = (sat_reg || (|root_reg[RT_W-1:16])) ? 16'hFFFF : root_reg[15:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && q_data.is_sample) begin
                    if (emit_first) begin
                        state_next = ST_MAC;
                    end else if (q_data.last) begin
                        state_next = ST_ADV;
                    end
                end
            end
            ST_MAC: begin
                if (k_reg == IDX_W'(TAPS - 1)) begin
                    state_next = ST_MAG;
                end
            end
            ST_MAG:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_SQRT;
            ST_SQRT: begin
                if (cnt_reg == CNT_W'(hfed_pkg::SQRT_CYCLES - 1)) begin
                    state_next = ST_RES;
                end
            end
            ST_RES: begin
                if (out_free) begin
                    state_next = flush_reg ? ST_ADV : ST_IDLE;
                end
            end
            ST_ADV: begin
                if (step_reg == STEP_W'(HALF)) begin
                    state_next = ST_IDLE;
                end else if (emit_adv) begin
                    state_next = ST_MAC;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            seen_reg    <= '0;
            flush_reg   <= 1'b0;
            step_reg    <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < TAPS; i++) begin
                dl_reg[i]  <= '0;
                tap_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_RES && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        if (q_data.is_sample) begin
                            for (int i = TAPS - 1; i > 0; i--) begin
                                dl_reg[i] <= dl_reg[i-1];
                            end
                            dl_reg[0] <= q_data.sample;
                            seen_reg  <= seen_inc;
                            flush_reg <= q_data.last;
                            step_reg  <= '0;
                            k_reg     <= '0;
                        end else if (q_data.wr_ok) begin
                            tap_reg[IDX_W'(q_data.tap_idx)] <= q_data.coef;
                        end
                    end
                end
                ST_MAC: k_reg <= k_reg + 1'b1;
                ST_ADV: begin
                    if (step_reg == STEP_W'(HALF)) begin
                        for (int i = 0; i < TAPS; i++) begin
                            dl_reg[i] <= '0;
                        end
                        seen_reg  <= '0;
                        flush_reg <= 1'b0;
                    end else begin
                        for (int i = TAPS - 1; i > 0; i--) begin
                            dl_reg[i] <= dl_reg[i-1];
                        end
                        dl_reg[0] <= '0;
                        step_reg  <= step_inc;
                        k_reg     <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: acc_reg <= '0;
            ST_ADV:  acc_reg <= '0;
            ST_MAC:  acc_reg <= acc_reg + ACC_W'(prod);
            ST_MAG: begin
                sat_reg   <= mag_big;
                magsq_reg <= mag_lo * mag_lo;
            end
            ST_SUM: begin
                // floor(sqrt(x)) >> 15 equals isqrt(x >> 30)
                rad_reg  <= 36'($unsigned(ssq)) + 36'(magsq_reg[61:30]);
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            ST_SQRT: begin
                rem_reg  <= st2.rem;
                root_reg <= st2.root;
                rad_reg  <= {rad_reg[31:0], 4'b0000};
                cnt_reg  <= cnt_reg + 1'b1;
            end
            ST_RES: begin
                if (out_free) begin
                    m_data_reg.envelope <= env;
                    m_data_reg.last_out <= flush_reg && (step_reg == STEP_W'(HALF));
                end
            end
            default: ;
        endcase
    end

    `HFED_ASSERT_IMPLIES(a_step_range, aclk, aresetn, 1'b1, step_reg <= STEP_W'(HALF))
    `HFED_ASSERT_IMPLIES(a_mac_index, aclk, aresetn, state_reg == ST_MAC, k_reg <= IDX_W'(TAPS - 1))
    `HFED_ASSERT_NEXT(a_res_loads_out, aclk, aresetn, state_reg == ST_RES && out_free, m_valid_reg)

endmodule

[hdl/hilbert_fir_envelope_detector_unit.sv]
// Top level of the Hilbert FIR envelope detector.
// Depends on hfed_pkg, hfed_front, hfed_queue and hfed_back.
//
// Input channel s_*: one item per handshake. mode 0 writes one Q1.15 filter
// coefficient (indexes at or beyond TAPS are dropped); mode 1 delivers one
// sample of the current scanline, last_sample marking the final one.
// Result channel m_*: one envelope per centre sample, last_out on the final.
// A sample item yields one result once TAPS/2 later samples have arrived;
// a last sample flushes up to TAPS/2+1 results with zeros past the end,
// then clears the delay line and the sample count.
// Each result passes through the one shared multiply-accumulate over all
// TAPS taps, magnitude squaring and the square root, which retires two root
// bits per cycle. The back end takes no new item while a result or a flush
// is in progress. A front register and a short queue absorb items while
// the back end works.
// Reset (aresetn low, synchronous) clears taps, delay line and all control.
// A stalled receiver holds the output register; the back end waits with the
// next result, and the front takes items until it and the queue are full.
module hilbert_fir_envelope_detector_unit #(
    parameter int TAPS   = hfed_pkg::TAPS_DEF,
    parameter int QDEPTH = hfed_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hfed_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hfed_pkg::out_item_t m_data
);

    logic           req_valid;
    logic           req_ready;
    hfed_pkg::cmd_t req_data;
    logic           q_valid;
    logic           q_ready;
    hfed_pkg::cmd_t q_data;

    hfed_front #(.TAPS(TAPS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data)
    );

    hfed_queue #(.DEPTH(QDEPTH)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (req_valid),
        .push_ready (req_ready),
        .push_data  (req_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    hfed_back #(.TAPS(TAPS)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
